[sv/vks_pkg.sv]
// vks_pkg: shared types, register map and constants for the velocity key scanner.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package vks_pkg;

	// field widths fixed by the interface
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned DISP_W   = 13;
	localparam int unsigned VEL_W    = 14;
	localparam int unsigned MINV_W   = 13;
	localparam int unsigned KEY_W    = 6;
	localparam int unsigned CHAN_W   = 4;
	localparam int unsigned GRP_W    = 6;
	localparam int unsigned ADDR_W   = 7;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	// register reset values
	localparam logic [SAMPLE_W-1:0] REST_RST = 12'd2110;
	localparam logic [SAMPLE_W-1:0] ATT_RST  = 12'd400;
	localparam logic [SAMPLE_W-1:0] REL_RST  = 12'd300;
	localparam logic [MINV_W-1:0]   MINV_RST = 13'd10;

	// register index (byte address / 4)
	typedef enum logic [1:0] {
		REG_RESTING     = 2'd0,
		REG_ATTACK_THR  = 2'd1,
		REG_RELEASE_THR = 2'd2,
		REG_MIN_VEL     = 2'd3
	} reg_idx_t;

	// result event codes
	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_ATTACK  = 2'd1,
		EV_RELEASE = 2'd2
	} event_t;

	// converter bus addresses of the key groups
	localparam logic [ADDR_W-1:0] BUS_ADDR_G0 = 7'h48;
	localparam logic [ADDR_W-1:0] BUS_ADDR_G1 = 7'h49;
	localparam logic [ADDR_W-1:0] BUS_ADDR_G2 = 7'h4A;
	localparam logic [ADDR_W-1:0] BUS_ADDR_G3 = 7'h4C;
	localparam logic [ADDR_W-1:0] BUS_ADDR_GL = 7'h4D;

	// configuration register set
	typedef struct packed {
		logic [SAMPLE_W-1:0] resting_level;
		logic [SAMPLE_W-1:0] attack_threshold;
		logic [SAMPLE_W-1:0] release_threshold;
		logic [MINV_W-1:0]   min_attack_velocity;
	} cfg_t;

	// per-key history entry
	typedef struct packed {
		logic                     pressed;
		logic signed [DISP_W-1:0] disp;
	} entry_t;

	// scan position of the key that follows the current one
	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [GRP_W-1:0]  grp;
	} scan_t;

	// group number to bus address; groups past the table take the last entry
	function automatic logic [ADDR_W-1:0] group_addr(input logic [GRP_W-1:0] grp);
		logic [ADDR_W-1:0] a;
		case (grp)
			6'd0:    a = BUS_ADDR_G0;
			6'd1:    a = BUS_ADDR_G1;
			6'd2:    a = BUS_ADDR_G2;
			6'd3:    a = BUS_ADDR_G3;
			default: a = BUS_ADDR_GL;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

[sv/vks_cfg_regs.sv]
// vks_cfg_regs: APB register file holding the scanner's resting level and thresholds.
// Depends on vks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vks_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vks_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [vks_pkg::PDATA_W-1:0]  pwdata,
	output logic      [vks_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output vks_pkg::cfg_t                     cfg
);

	vks_pkg::cfg_t     cfg_q;
	vks_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = vks_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resting_level       <= vks_pkg::REST_RST;
			cfg_q.attack_threshold    <= vks_pkg::ATT_RST;
			cfg_q.release_threshold   <= vks_pkg::REL_RST;
			cfg_q.min_attack_velocity <= vks_pkg::MINV_RST;
		end else if (wr_en) begin
			unique case (idx)
				vks_pkg::REG_RESTING:     cfg_q.resting_level     <= pwdata[11:0];
				vks_pkg::REG_ATTACK_THR:  cfg_q.attack_threshold  <= pwdata[11:0];
				vks_pkg::REG_RELEASE_THR: cfg_q.release_threshold <= pwdata[11:0];
				vks_pkg::REG_MIN_VEL:     cfg_q.min_attack_velocity <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			vks_pkg::REG_RESTING:     prdata = 32'(cfg_q.resting_level);
			vks_pkg::REG_ATTACK_THR:  prdata = 32'(cfg_q.attack_threshold);
			vks_pkg::REG_RELEASE_THR: prdata = 32'(cfg_q.release_threshold);
			vks_pkg::REG_MIN_VEL:     prdata = 32'(cfg_q.min_attack_velocity);
			default:                  prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[sv/vks_scan_ctr.sv]
// vks_scan_ctr: round-robin key index with running mux channel and group counters.
// Depends on vks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vks_scan_ctr #(
	parameter int unsigned KEY_COUNT      = 60,
	parameter int unsigned KEYS_PER_GROUP = 12,
	parameter int unsigned KW             = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	output logic [KW-1:0]      key,
	output vks_pkg::scan_t     pos_nxt
);

	logic [KW-1:0]                  key_q;
	logic [KW-1:0]                  key_nxt;
	logic [vks_pkg::CHAN_W-1:0]     chan_q;
	logic [vks_pkg::GRP_W-1:0]      grp_q;
	logic                           key_wrap;
	logic                           chan_wrap;

	assign key_wrap  = (key_q == KW'(KEY_COUNT - 1));
	assign chan_wrap = (chan_q == vks_pkg::CHAN_W'(KEYS_PER_GROUP - 1));

	// position of the following key; channel and group count along with the key
	always_comb begin
		if (key_wrap) begin
			key_nxt      = '0;
			pos_nxt.chan = '0;
			pos_nxt.grp  = '0;
		end else begin
			key_nxt      = key_q + KW'(1);
			pos_nxt.chan = chan_wrap ? '0 : chan_q + vks_pkg::CHAN_W'(1);
			pos_nxt.grp  = chan_wrap ? grp_q + vks_pkg::GRP_W'(1) : grp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			chan_q <= '0;
			grp_q  <= '0;
		end else if (step) begin
			key_q  <= key_nxt;
			chan_q <= pos_nxt.chan;
			grp_q  <= pos_nxt.grp;
		end
	end

	assign key = key_q;

endmodule
`default_nettype wire

[sv/vks_key_store.sv]
// vks_key_store: per-key history memory (last displacement, pressed flag) with
// reset-cleared valid bits and write-to-read forwarding. Depends on vks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vks_key_store #(
	parameter int unsigned KEY_COUNT = 60,
	parameter int unsigned KW        = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           rd_en,
	input  wire logic [KW-1:0]  rd_addr,
	output vks_pkg::entry_t     rd_data,
	input  wire logic           wr_en,
	input  wire logic [KW-1:0]  wr_addr,
	input  wire vks_pkg::entry_t wr_data
);

	vks_pkg::entry_t mem_q [KEY_COUNT];
	logic            vld_q [KEY_COUNT];
	vks_pkg::entry_t rdat_s1;
	vks_pkg::entry_t fdat_s1;
	logic            rvld_s1;
	logic            fwd_s1;

	// memory write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, with a bypass when the same key is written in that cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdat_s1 <= mem_q[rd_addr];
			fdat_s1 <= wr_data;
		end
	end

	// valid bits: an entry never written reads as cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_COUNT; i++) begin
				vld_q[i] <= 1'b0;
			end
			rvld_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
				fwd_s1  <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	always_comb begin
		if (fwd_s1) begin
			rd_data = fdat_s1;
		end else if (rvld_s1) begin
			rd_data = rdat_s1;
		end else begin
			rd_data = '0;
		end
	end

endmodule
`default_nettype wire

[sv/velocity_key_scanner.sv]
// velocity_key_scanner: hall-sensor key scanner, top level.
// Pipeline: stage 1 registers the sample word and scan position, stage 2 the result
// word, which holds while the event side stalls. Throughput: one sample word per
// cycle unless the event side stalls, set by the single read and write port of the
// per-key history memory (read at intake, written as the result registers).
// Reset: scan position goes to key 0, all keys read as released with zero history
// at once (valid bits, no clearing pass), registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module velocity_key_scanner #(
	parameter int unsigned KEY_COUNT      = 60,
	parameter int unsigned KEYS_PER_GROUP = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// APB configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [vks_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [vks_pkg::PDATA_W-1:0]         pwdata,
	output logic      [vks_pkg::PDATA_W-1:0]         prdata,
	output logic                                     pready,
	// sample channel
	input  wire logic                                sample_valid,
	output logic                                     sample_ready,
	input  wire logic [vks_pkg::SAMPLE_W-1:0]        sample,
	// event channel
	output logic                                     event_valid,
	input  wire logic                                event_ready,
	output logic [1:0]                               event_kind,
	output logic [vks_pkg::KEY_W-1:0]                key_index,
	output logic signed [vks_pkg::VEL_W-1:0]         strike_velocity,
	output logic [vks_pkg::CHAN_W-1:0]               next_mux_channel,
	output logic [vks_pkg::ADDR_W-1:0]               next_bus_address
);

	localparam int unsigned KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	vks_pkg::cfg_t   cfg;
	vks_pkg::scan_t  pos_nxt;
	vks_pkg::entry_t hist;
	vks_pkg::entry_t upd;
	logic [KW-1:0]   key_cur;
	logic            take;
	logic            adv_s1;

	// stage 1: sample word plus scan position
	logic                          valid_s1;
	logic [vks_pkg::SAMPLE_W-1:0]  sample_s1;
	logic [KW-1:0]                 key_s1;
	vks_pkg::scan_t                pos_s1;

	// stage 2: result word
	logic                             valid_s2;
	vks_pkg::event_t                  kind_s2;
	logic [KW-1:0]                    key_s2;
	logic signed [vks_pkg::VEL_W-1:0] vel_s2;
	logic [vks_pkg::CHAN_W-1:0]       chan_s2;
	logic [vks_pkg::ADDR_W-1:0]       addr_s2;

	// evaluation
	logic signed [vks_pkg::DISP_W-1:0] disp;
	logic signed [vks_pkg::VEL_W-1:0]  vel;
	logic                              do_attack;
	logic                              do_release;
	vks_pkg::event_t                   kind;

	vks_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vks_scan_ctr #(
		.KEY_COUNT      (KEY_COUNT),
		.KEYS_PER_GROUP (KEYS_PER_GROUP),
		.KW             (KW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (take),
		.key     (key_cur),
		.pos_nxt (pos_nxt)
	);

	vks_key_store #(
		.KEY_COUNT (KEY_COUNT),
		.KW        (KW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_addr (key_cur),
		.rd_data (hist),
		.wr_en   (adv_s1),
		.wr_addr (key_s1),
		.wr_data (upd)
	);

	// handshake: stage 1 moves on whenever the result register is free or drained
	assign adv_s1       = valid_s1 && (!valid_s2 || event_ready);
	assign sample_ready = !valid_s1 || adv_s1;
	assign take         = sample_valid && sample_ready;

	// displacement, velocity and hysteresis decision
	assign disp = $signed({1'b0, sample_s1}) - $signed({1'b0, cfg.resting_level});
	assign vel  = $signed({disp[vks_pkg::DISP_W-1], disp})
		- $signed({hist.disp[vks_pkg::DISP_W-1], hist.disp});
	assign do_attack = !hist.pressed
		&& (disp > $signed({1'b0, cfg.attack_threshold}))
		&& (vel >= $signed({1'b0, cfg.min_attack_velocity}));
	assign do_release = hist.pressed
		&& (disp < $signed({1'b0, cfg.release_threshold}));

	always_comb begin
		if (do_attack) begin
			kind = vks_pkg::EV_ATTACK;
		end else if (do_release) begin
			kind = vks_pkg::EV_RELEASE;
		end else begin
			kind = vks_pkg::EV_NONE;
		end
	end

	assign upd.pressed = (hist.pressed | do_attack) & ~do_release;
	assign upd.disp    = disp;

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (!valid_s2 || event_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
			key_s1    <= key_cur;
			pos_s1    <= pos_nxt;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s2 <= kind;
			key_s2  <= key_s1;
			vel_s2  <= vel;
			chan_s2 <= pos_s1.chan;
			addr_s2 <= vks_pkg::group_addr(pos_s1.grp);
		end
	end

	assign event_valid      = valid_s2;
	assign event_kind       = kind_s2;
	assign key_index        = vks_pkg::KEY_W'(key_s2);
	assign strike_velocity  = vel_s2;
	assign next_mux_channel = chan_s2;
	assign next_bus_address = addr_s2;

endmodule
`default_nettype wire

[sv/vks_checker.sv]
// vks_checker: port-level checks on the scanner's event channel, bound to the top.
// Depends on vks_pkg and velocity_key_scanner.
`timescale 1ns / 1ps
`default_nettype none
module vks_checker #(
	parameter int unsigned KEY_COUNT      = 60,
	parameter int unsigned KEYS_PER_GROUP = 12
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             event_valid,
	input wire logic                             event_ready,
	input wire logic [1:0]                       event_kind,
	input wire logic [vks_pkg::KEY_W-1:0]        key_index,
	input wire logic signed [vks_pkg::VEL_W-1:0] strike_velocity,
	input wire logic [vks_pkg::CHAN_W-1:0]       next_mux_channel
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !event_ready |=> event_valid && $stable(key_index)
			&& $stable(event_kind) && $stable(strike_velocity))
		else $error("event word changed while stalled");

	// key in range and event code defined
	a_key: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> (32'(key_index) < KEY_COUNT)
			&& (event_kind != 2'd3))
		else $error("bad key index or event code");

	// an attack carries a non-negative velocity, as the minimum it must meet is non-negative
	a_att: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (event_kind == vks_pkg::EV_ATTACK) |-> !strike_velocity[vks_pkg::VEL_W-1])
		else $error("attack with negative velocity");

	// channel stays within a group
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> (32'(next_mux_channel) < KEYS_PER_GROUP))
		else $error("mux channel out of range");

endmodule

bind velocity_key_scanner vks_checker #(
	.KEY_COUNT      (KEY_COUNT),
	.KEYS_PER_GROUP (KEYS_PER_GROUP)
) u_vks_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.event_valid      (event_valid),
	.event_ready      (event_ready),
	.event_kind       (event_kind),
	.key_index        (key_index),
	.strike_velocity  (strike_velocity),
	.next_mux_channel (next_mux_channel)
);
`default_nettype wire
